FILE: design/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg: shared types and constants for the angle/bias Kalman filter
// Widths, register indexes, reset values and the micro-op encoding.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int unsigned REG_W   = 31;
	localparam int unsigned MEAS_W  = 25;
	localparam int unsigned RATE_W  = 28;
	localparam int unsigned DT_W    = 24;
	localparam int unsigned ST_W    = 32;
	localparam int unsigned IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_QA = 2'd0;
	localparam logic [IDX_W-1:0] REG_QB = 2'd1;
	localparam logic [IDX_W-1:0] REG_R  = 2'd2;

	localparam logic [REG_W-1:0] QA_RESET = 31'd10737418;
	localparam logic [REG_W-1:0] QB_RESET = 31'd322123;
	localparam logic [REG_W-1:0] R_RESET  = 31'd10737418;

	// micro-op sequence: predict, gains, correct
	localparam int unsigned OP_W = 4;
	localparam logic [OP_W-1:0] OP_ANG_PRED = 4'd0;
	localparam logic [OP_W-1:0] OP_AA_QA    = 4'd1;
	localparam logic [OP_W-1:0] OP_AA_CROSS = 4'd2;
	localparam logic [OP_W-1:0] OP_AB_PRED  = 4'd3;
	localparam logic [OP_W-1:0] OP_BA_PRED  = 4'd4;
	localparam logic [OP_W-1:0] OP_BB_PRED  = 4'd5;
	localparam logic [OP_W-1:0] OP_K0       = 4'd6;
	localparam logic [OP_W-1:0] OP_K1       = 4'd7;
	localparam logic [OP_W-1:0] OP_BIAS_COR = 4'd8;
	localparam logic [OP_W-1:0] OP_ANG_COR  = 4'd9;
	localparam logic [OP_W-1:0] OP_AA_COR   = 4'd10;
	localparam logic [OP_W-1:0] OP_AB_COR   = 4'd11;
	localparam logic [OP_W-1:0] OP_BA_COR   = 4'd12;
	localparam logic [OP_W-1:0] OP_BB_COR   = 4'd13;

	// serial multiplier: signed a (<=34b) times signed b (<=34b)
	localparam int unsigned MUL_W  = 34;
	localparam int unsigned PROD_W = 2 * MUL_W;
	// serial divider: 64-bit dividend magnitude
	localparam int unsigned DIV_W  = 64;

	function automatic logic signed [ST_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(64'sh7FFF_FFFF);
		lo = -PROD_W'(64'sh8000_0000);
		if (v > hi) begin
			return ST_W'(hi);
		end else if (v < lo) begin
			return ST_W'(lo);
		end
		return v[ST_W-1:0];
	endfunction

	// round to nearest, halves up, by 2^s (arithmetic shift floors)
	function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
			input logic [4:0] s);
		logic signed [PROD_W-1:0] w;
		w = v + (PROD_W'(1) <<< (s - 5'd1));
		return w >>> s;
	endfunction

endpackage

FILE: design/kabf_mul.sv
// ----------------------------------------------------------------------------
// kabf_mul: bit-serial signed multiplier
// Shift-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module kabf_mul (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [kabf_pkg::MUL_W-1:0]     a,
	input  logic signed [kabf_pkg::MUL_W-1:0]     b,
	output logic                                   done,
	output logic signed [kabf_pkg::PROD_W-1:0]    prod
);
	localparam int unsigned CW = $clog2(kabf_pkg::MUL_W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic signed [kabf_pkg::PROD_W-1:0] acc_q, mcand_q;
	logic [kabf_pkg::MUL_W-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(kabf_pkg::MUL_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// the sign bit of b has negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= kabf_pkg::PROD_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CW'(kabf_pkg::MUL_W - 1)) acc_q <= acc_q - mcand_q;
				else acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

FILE: design/kabf_div.sv
// ----------------------------------------------------------------------------
// kabf_div: bit-serial signed divider, quotient truncated toward zero
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kabf_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [kabf_pkg::DIV_W-1:0]    num,
	input  logic signed [kabf_pkg::DIV_W-1:0]    den,
	output logic                                  done,
	output logic signed [kabf_pkg::DIV_W-1:0]    quo
);
	localparam int unsigned W  = kabf_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q, neg_q;
	logic [W-1:0] q_q, d_q;
	logic [W:0] r_q, r_sh;

	assign r_sh = {r_q[W-1:0], q_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[W-1] ? W'(-num) : W'(num);
			d_q   <= den[W-1] ? W'(-den) : W'(den);
			r_q   <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

FILE: design/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state angle/gyro-bias Kalman filter
// Each item runs twelve serial multiplies and two serial divides, plus the
// load, on the shared bit-serial units; the next item is accepted only when
// the last has finished. A new item is taken while a result waits, the last
// step holds until it leaves.
// Reset clears the state and loads register defaults; output idles empty.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [kabf_pkg::MEAS_W-1:0]     measured_angle,
	input  logic signed [kabf_pkg::RATE_W-1:0]     gyro_rate,
	input  logic [kabf_pkg::DT_W-1:0]              time_step,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [kabf_pkg::ST_W-1:0]       filtered_angle,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [kabf_pkg::IDX_W-1:0]             cfg_index,
	input  logic [kabf_pkg::REG_W-1:0]             cfg_data
);
	localparam int unsigned PW = kabf_pkg::PROD_W;
	localparam int unsigned MW = kabf_pkg::MUL_W;
	localparam int unsigned DW = kabf_pkg::DIV_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [kabf_pkg::OP_W-1:0] step_q;
	logic [kabf_pkg::REG_W-1:0] qa_q, qb_q, r_q;
	logic signed [kabf_pkg::ST_W-1:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q, k0_q, k1_q;
	logic signed [kabf_pkg::MEAS_W-1:0] meas_q;
	logic signed [kabf_pkg::RATE_W-1:0] rate_q;
	logic [kabf_pkg::DT_W-1:0] dt_q;
	logic signed [PW-1:0] t_q;
	logic signed [kabf_pkg::ST_W-1:0] out_q;
	logic out_v_q;

	logic mul_start, mul_done, div_start, div_done;
	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] mp;
	logic signed [DW-1:0] dnum, dden, dq;
	logic signed [PW-1:0] s_w, y_w, r24, r30;

	assign s_w = PW'(aa_q) + PW'($signed({1'b0, r_q}));
	assign y_w = PW'(meas_q) - PW'(ang_q);
	assign r24 = kabf_pkg::rshr(mp, 5'd24);
	assign r30 = kabf_pkg::rshr(mp, 5'd30);

	kabf_mul u_mul (.clk, .arst_n, .start(mul_start), .a(ma), .b(mb),
		.done(mul_done), .prod(mp));
	kabf_div u_div (.clk, .arst_n, .start(div_start), .num(dnum), .den(dden),
		.done(div_done), .quo(dq));

	// bias is corrected before the angle so both see the predicted innovation
	logic signed [MW-1:0] dt_m;
	assign dt_m = MW'($signed({1'b0, dt_q}));
	always_comb begin
		ma = dt_m;
		mb = '0;
		dnum = '0;
		case (step_q)
			kabf_pkg::OP_ANG_PRED: mb = MW'(rate_q) - MW'(bias_q);
			kabf_pkg::OP_AA_QA: mb = MW'($signed({1'b0, qa_q}));
			kabf_pkg::OP_AA_CROSS: mb = MW'(ba_q) + MW'(ab_q);
			kabf_pkg::OP_AB_PRED, kabf_pkg::OP_BA_PRED: mb = MW'(bb_q);
			kabf_pkg::OP_BB_PRED: mb = MW'($signed({1'b0, qb_q}));
			kabf_pkg::OP_BIAS_COR: begin ma = MW'(k1_q); mb = MW'(y_w); end
			kabf_pkg::OP_ANG_COR: begin ma = MW'(k0_q); mb = MW'(y_w); end
			kabf_pkg::OP_AA_COR: begin ma = MW'(k0_q); mb = MW'(aa_q); end
			kabf_pkg::OP_AB_COR: begin ma = MW'(k0_q); mb = MW'(ab_q); end
			kabf_pkg::OP_BA_COR: begin ma = MW'(k1_q); mb = MW'(aa_q); end
			kabf_pkg::OP_BB_COR: begin ma = MW'(k1_q); mb = MW'(ab_q); end
			default: mb = '0;
		endcase
		dnum = (step_q == kabf_pkg::OP_K0) ? (DW'(aa_q) <<< 30) : (DW'(ba_q) <<< 30);
		dden = DW'(s_w);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign filtered_angle = out_q;

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_v_q || out_ready);

	logic go_q;
	assign mul_start = go_q && (step_q <= kabf_pkg::OP_BB_PRED || step_q >= kabf_pkg::OP_BIAS_COR);
	assign div_start = go_q && (step_q == kabf_pkg::OP_K0 || step_q == kabf_pkg::OP_K1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			go_q <= (state_q == ST_IDLE && in_valid && in_ready) ||
				(state_q == ST_MUL && mul_done && step_q != kabf_pkg::OP_BB_COR) ||
				(state_q == ST_DIV && div_done);
			if (out_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= kabf_pkg::OP_ANG_PRED;
			qa_q <= kabf_pkg::QA_RESET;
			qb_q <= kabf_pkg::QB_RESET;
			r_q  <= kabf_pkg::R_RESET;
			ang_q <= '0; bias_q <= '0; aa_q <= '0; ab_q <= '0; ba_q <= '0; bb_q <= '0;
			k0_q <= '0; k1_q <= '0; t_q <= '0; out_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kabf_pkg::REG_QA: qa_q <= cfg_data;
					kabf_pkg::REG_QB: qb_q <= cfg_data;
					kabf_pkg::REG_R:  r_q  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					state_q <= ST_MUL;
					step_q  <= kabf_pkg::OP_ANG_PRED;
				end
				ST_MUL: if (mul_done) begin
					step_q <= step_q + 4'd1;
					case (step_q)
						kabf_pkg::OP_ANG_PRED: ang_q <= kabf_pkg::sat32(PW'(ang_q) + r24);
						kabf_pkg::OP_AA_QA: t_q <= PW'(aa_q) + r24;
						kabf_pkg::OP_AA_CROSS: aa_q <= kabf_pkg::sat32(t_q - r24);
						kabf_pkg::OP_AB_PRED: ab_q <= kabf_pkg::sat32(PW'(ab_q) - r24);
						kabf_pkg::OP_BA_PRED: ba_q <= kabf_pkg::sat32(PW'(ba_q) - r24);
						kabf_pkg::OP_BB_PRED: begin
							bb_q <= kabf_pkg::sat32(PW'(bb_q) + r24);
							state_q <= ST_DIV;
						end
						kabf_pkg::OP_BIAS_COR: bias_q <= kabf_pkg::sat32(PW'(bias_q) + r30);
						kabf_pkg::OP_ANG_COR: ang_q <= kabf_pkg::sat32(PW'(ang_q) + r30);
						kabf_pkg::OP_AA_COR: aa_q <= kabf_pkg::sat32(PW'(aa_q) - r30);
						kabf_pkg::OP_AB_COR: ab_q <= kabf_pkg::sat32(PW'(ab_q) - r30);
						kabf_pkg::OP_BA_COR: ba_q <= kabf_pkg::sat32(PW'(ba_q) - r30);
						default: begin
							bb_q <= kabf_pkg::sat32(PW'(bb_q) - r30);
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_DIV: if (div_done) begin
					step_q <= step_q + 4'd1;
					if (step_q == kabf_pkg::OP_K0) begin
						k0_q <= (s_w == '0) ? '0 : kabf_pkg::sat32(PW'(dq));
					end else begin
						k1_q <= (s_w == '0) ? '0 : kabf_pkg::sat32(PW'(dq));
						state_q <= ST_MUL;
					end
				end
				ST_OUT: if (out_load) begin
					out_q   <= ang_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_q <= measured_angle;
			rate_q <= gyro_rate;
			dt_q   <= time_step;
		end
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start))
		else $error("multiplier and divider started together");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input accepted while busy");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid)
		else $error("result not presented");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(filtered_angle)))
		else $error("waiting result changed");
endmodule
